### rtl/itoa_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
package itoa_pkg;

   localparam int VALUE_W      = 32;
   localparam int DIGIT_W      = 4;
   localparam int NUM_DIGITS   = 10;
   localparam int DABBLE_STEPS = 32;
   localparam int STEP_W       = 5;
   localparam int COUNT_W      = 32;

   typedef logic [1:0]                     mode_type;
   typedef logic [VALUE_W-1:0]             value_type;
   typedef logic [7:0]                     ascii_type;
   typedef logic [COUNT_W-1:0]             count_type;
   typedef logic [DIGIT_W-1:0]             digit_type;
   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_vec_type;
   typedef logic [3:0]                     digit_index_type;

   localparam mode_type MODE_DEC       = 2'd0;
   localparam mode_type MODE_HEX_LOWER = 2'd1;
   localparam mode_type MODE_HEX_UPPER = 2'd2;

   localparam ascii_type ASCII_ZERO        = 8'd48;
   localparam ascii_type ASCII_MINUS       = 8'd45;
   localparam ascii_type LOWER_LETTER_BASE = 8'd87;
   localparam ascii_type UPPER_LETTER_BASE = 8'd55;

   localparam digit_type DEC_RADIX = 4'd10;
   localparam digit_type ADJUST_AT = 4'd5;
   localparam digit_type ADJUST_BY = 4'd3;

endpackage

### rtl/itoa_if.sv
// Request and response channel interfaces of the integer to ASCII formatter.
interface itoa_req_if;
   import itoa_pkg::*;
   logic      valid;
   logic      ready;
   mode_type  mode;
   value_type value;
   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface itoa_rsp_if;
   import itoa_pkg::*;
   logic      valid;
   logic      ready;
   ascii_type character;
   logic      last;
   count_type total_count;
   modport source (output valid, output character, output last, output total_count,
                   input ready);
   modport sink   (input valid, input character, input last, input total_count,
                   output ready);
endinterface

### rtl/itoa_digit_unit.sv
// Shared digit unit: one shift-and-add-3 binary to BCD step and leading digit search.
module itoa_digit_unit (
   input  itoa_pkg::digit_vec_type   digits_in,
   input  itoa_pkg::value_type       bin_in,
   output itoa_pkg::digit_vec_type   digits_out,
   output itoa_pkg::value_type       bin_out,
   output itoa_pkg::digit_index_type msd_index
);
   import itoa_pkg::*;

   digit_vec_type                     adj;
   logic [DIGIT_W*NUM_DIGITS-1:0]     adj_flat;

   // Correct each BCD lane before the shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (digits_in[i] >= ADJUST_AT) ? digits_in[i] + ADJUST_BY : digits_in[i];
      end
   end

   assign adj_flat   = adj;
   assign digits_out = digit_vec_type'({adj_flat[DIGIT_W*NUM_DIGITS-2:0], bin_in[VALUE_W-1]});
   assign bin_out    = {bin_in[VALUE_W-2:0], 1'b0};

   // Highest nonzero digit; zero value points at the lowest digit.
   always_comb begin
      msd_index = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (digits_in[i] != '0) begin
            msd_index = digit_index_type'(i);
         end
      end
   end

endmodule

### rtl/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: sequencer, digit store and output register.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+----------------------------------------
//  req     | in  | valid / ready   | mode (2), value (32)
//  rsp     | out | valid / ready   | character (8), last (1), total_count (32)
//
// Decimal requests are accepted, then take 32 binary-to-BCD steps through the shared
// digit unit and a leading digit search, then one character per cycle (up to 11) unless stalled.
// Hex requests skip the BCD steps: accept, search, then up to 8 characters.
// Reset (synchronous) clears the sequencer, the output valid and the character count.
// A stalled response holds the character register and the sequencer in its minus or emit state;
// a new request is taken as soon as the last character sits in the output register.
module integer_to_ascii_formatter_unit (
   input  logic       clock,
   input  logic       reset,
   itoa_req_if.sink   req_chan,
   itoa_rsp_if.source rsp_chan
);
   import itoa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_FIND,
      ST_MINUS,
      ST_EMIT
   } state_type;

   state_type       state_ff, state_in;
   digit_vec_type   digits_ff, digits_in;
   value_type       bin_ff, bin_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic            neg_ff, neg_in;
   logic            upper_ff, upper_in;
   digit_index_type idx_ff, idx_in;
   count_type       count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   ascii_type       char_ff, char_in;
   logic            last_ff, last_in;

   digit_vec_type   step_digits;
   value_type       step_bin;
   digit_index_type msd_idx;

   logic            slot_free;
   digit_type       cur_digit;
   ascii_type       cur_ascii;
   logic            slot_load;

   itoa_digit_unit u_digit (
      .digits_in  (digits_ff),
      .bin_in     (bin_ff),
      .digits_out (step_digits),
      .bin_out    (step_bin),
      .msd_index  (msd_idx)
   );

   // Output register is free when empty or being drained this cycle.
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Map the current digit to ASCII; decimal digits never reach the letter range.
   assign cur_digit = digits_ff[idx_ff];
   assign cur_ascii = (cur_digit < DEC_RADIX)
                      ? ASCII_ZERO + {4'b0000, cur_digit}
                      : (upper_ff ? UPPER_LETTER_BASE : LOWER_LETTER_BASE) + {4'b0000, cur_digit};

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      bin_in       = bin_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      upper_in     = upper_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      slot_load    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.mode == MODE_DEC) begin
                  // Take the magnitude; the most negative value wraps to 2^31 unsigned.
                  neg_in    = req_chan.value[VALUE_W-1];
                  bin_in    = req_chan.value[VALUE_W-1] ? value_type'(0) - req_chan.value
                                                        : req_chan.value;
                  digits_in = '0;
                  step_in   = '0;
                  upper_in  = 1'b1;
                  state_in  = ST_CONVERT;
               end else begin
                  // Hex digits are the nibbles themselves.
                  neg_in    = 1'b0;
                  upper_in  = (req_chan.mode != MODE_HEX_LOWER);
                  digits_in = digit_vec_type'({{(DIGIT_W*NUM_DIGITS-VALUE_W){1'b0}},
                                               req_chan.value});
                  state_in  = ST_FIND;
               end
            end
         end
         ST_CONVERT: begin
            // Advance one binary-to-BCD step.
            digits_in = step_digits;
            bin_in    = step_bin;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(DABBLE_STEPS-1)) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            idx_in   = msd_idx;
            state_in = neg_ff ? ST_MINUS : ST_EMIT;
         end
         ST_MINUS: begin
            if (slot_free) begin
               slot_load    = 1'b1;
               rsp_valid_in = 1'b1;
               char_in      = ASCII_MINUS;
               last_in      = 1'b0;
               count_in     = count_ff + 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               slot_load    = 1'b1;
               rsp_valid_in = 1'b1;
               char_in      = cur_ascii;
               last_in      = (idx_ff == '0);
               count_in     = count_ff + 1'b1;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      digits_ff <= digits_in;
      bin_ff    <= bin_in;
      step_ff   <= step_in;
      neg_ff    <= neg_in;
      upper_ff  <= upper_in;
      idx_ff    <= idx_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.character   = char_ff;
   assign rsp_chan.last        = last_ff;
   assign rsp_chan.total_count = count_ff;

   // A minus sign always has digits after it.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.character == ASCII_MINUS) |-> !rsp_chan.last)
      else $error("minus sign marked as last character");

   // Every loaded character bumps the running count by one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      slot_load |=> count_ff == $past(count_ff) + 1'b1)
      else $error("character count did not advance by one");

   // The block goes busy after taking a request.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("ready stayed high after a request was taken");

   // Loading the final character returns the sequencer to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      slot_load && last_in |=> state_ff == ST_IDLE)
      else $error("sequencer not idle after the last character");

endmodule
